@@ rtl/core/elt_pkg.sv @@
// Package for the exec-line tokenizer: character codes, result kinds,
// pending-escape codes and the result record. No dependencies.
package elt_pkg;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_PCT    = 8'h25;

    localparam logic [7:0] ARG_LIMIT_RESET = 8'd101;

    // Result queue: two slots per item plus headroom for a full-rate stream
    localparam int unsigned RQ_DEPTH = 4;
    localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);

    typedef enum logic {
        OP_CHAR = 1'b0,
        OP_END  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_END  = 2'd1,
        KIND_DONE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_ESC  = 2'd1,
        PEND_PCT  = 2'd2
    } pend_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_char;
        logic       status;
        logic [7:0] arg_total;
        logic       last;
    } res_t;

endpackage

@@ rtl/core/exec_line_tokenizer.sv @@
// Top level of the exec-line tokenizer: per-character split logic and a
// small result queue. Depends on elt_pkg.
//
// Results are registered in the result queue before they appear on m_*.
// Throughput: one input transfer per cycle; an end-of-string transfer makes
// up to two results, drained one per cycle while m_tready is high, and
// s_tready drops only while the four-entry result queue holds three or more results.
// Reset: aresetn is synchronous, active low; it clears the tokenizer state,
// empties the queue and sets the argument limit to 101.
module exec_line_tokenizer (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: argument limit
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tuser,   // [0] opcode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_char, [8] status, [16:9] arg_total
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // last result of the input transfer
);

    localparam int unsigned AW = elt_pkg::RQ_AW;

    // Tokenizer state
    logic [7:0]          arg_limit_reg;
    logic                quoted_reg, quoted_next;
    elt_pkg::pend_t      pending_reg, pending_next;
    logic                arg_open_reg, arg_open_next;
    logic [7:0]          arg_cnt_reg, arg_cnt_next;

    // Result queue
    elt_pkg::res_t       rq_reg [elt_pkg::RQ_DEPTH];
    logic [AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [AW:0]         count_reg, count_next;

    logic                s_xfer, m_xfer;
    logic                keeping;
    logic                parse_fail;
    elt_pkg::res_t       res0, res1;
    logic [1:0]          n_res;
    elt_pkg::res_t       head;

    assign s_xfer  = s_tvalid && s_tready;
    assign m_xfer  = m_tvalid && m_tready;
    assign keeping = arg_cnt_reg < arg_limit_reg;
    assign parse_fail = quoted_reg || (pending_reg == elt_pkg::PEND_ESC)
                        || (pending_reg == elt_pkg::PEND_PCT);

    // Per-item decision: next state and up to two results
    always_comb begin
        quoted_next   = quoted_reg;
        pending_next  = pending_reg;
        arg_open_next = arg_open_reg;
        arg_cnt_next  = arg_cnt_reg;
        n_res         = 2'd0;
        res0          = '{kind: elt_pkg::KIND_CHAR, out_char: 8'd0, status: 1'b0,
                          arg_total: 8'd0, last: 1'b1};
        res1          = res0;

        if (s_tuser == elt_pkg::OP_END) begin
            // End of string: close the open argument, report, start over
            res0.kind = elt_pkg::KIND_DONE;
            n_res     = 2'd1;
            if (parse_fail) begin
                res0.status = 1'b1;
            end else if (arg_open_reg && keeping) begin
                res0.kind      = elt_pkg::KIND_END;
                res0.last      = 1'b0;
                res1.kind      = elt_pkg::KIND_DONE;
                res1.arg_total = arg_cnt_reg + 8'd1;
                n_res          = 2'd2;
            end else begin
                res0.arg_total = arg_cnt_reg;
            end
            quoted_next   = 1'b0;
            pending_next  = elt_pkg::PEND_NONE;
            arg_open_next = 1'b0;
            arg_cnt_next  = 8'd0;
        end else begin
            pending_next = elt_pkg::PEND_NONE;
            res0.out_char = s_tdata;
            case (pending_reg)
                elt_pkg::PEND_ESC: begin
                    // Escaped character passes through literally
                    arg_open_next = 1'b1;
                    n_res         = keeping ? 2'd1 : 2'd0;
                end
                elt_pkg::PEND_PCT: begin
                    // Double percent gives one; any other code is dropped
                    if (s_tdata == elt_pkg::CH_PCT) begin
                        arg_open_next = 1'b1;
                        n_res         = keeping ? 2'd1 : 2'd0;
                    end
                end
                default: begin
                    if (!quoted_reg && (s_tdata inside
                            {elt_pkg::CH_SPACE, elt_pkg::CH_TAB, elt_pkg::CH_NL})) begin
                        // Separator: close the argument only if one has begun
                        if (arg_open_reg && keeping) begin
                            res0.kind     = elt_pkg::KIND_END;
                            res0.out_char = 8'd0;
                            n_res         = 2'd1;
                            arg_cnt_next  = arg_cnt_reg + 8'd1;
                        end
                        arg_open_next = 1'b0;
                    end else if (s_tdata == elt_pkg::CH_QUOTE) begin
                        quoted_next = ~quoted_reg;
                    end else if (s_tdata == elt_pkg::CH_BSLASH) begin
                        pending_next = elt_pkg::PEND_ESC;
                    end else if (s_tdata == elt_pkg::CH_PCT) begin
                        pending_next = elt_pkg::PEND_PCT;
                    end else begin
                        arg_open_next = 1'b1;
                        n_res         = keeping ? 2'd1 : 2'd0;
                    end
                end
            endcase
        end
    end

    // Queue pointers: push up to two results, pop one
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (s_xfer) begin
            wr_ptr_next = wr_ptr_reg + AW'(n_res);
            count_next  = count_next + (AW+1)'(n_res);
        end
        if (m_xfer) begin
            rd_ptr_next = rd_ptr_reg + AW'(1);
            count_next  = count_next - (AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arg_limit_reg <= elt_pkg::ARG_LIMIT_RESET;
            quoted_reg    <= 1'b0;
            pending_reg   <= elt_pkg::PEND_NONE;
            arg_open_reg  <= 1'b0;
            arg_cnt_reg   <= 8'd0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end else begin
            if (cfg_we) begin
                arg_limit_reg <= cfg_wdata;
            end
            if (s_xfer) begin
                quoted_reg   <= quoted_next;
                pending_reg  <= pending_next;
                arg_open_reg <= arg_open_next;
                arg_cnt_reg  <= arg_cnt_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage; payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_xfer && (n_res != 2'd0)) begin
            rq_reg[wr_ptr_reg] <= res0;
        end
        if (s_xfer && (n_res == 2'd2)) begin
            rq_reg[wr_ptr_reg + AW'(1)] <= res1;
        end
    end

    // Accept only with room for the worst case of two results
    assign s_tready = count_reg <= (AW+1)'(elt_pkg::RQ_DEPTH - 2);

    assign head     = rq_reg[rd_ptr_reg];
    assign m_tvalid = count_reg != '0;
    assign m_tdata  = {7'd0, head.arg_total, head.status, head.out_char};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

endmodule
